[sv/ras_pkg.sv]
// ----------------------------------------------------------------------------
// ras_pkg
// shared types and constants of the room allocation scheduler
// ----------------------------------------------------------------------------
package ras_pkg;

    localparam int DEF_MAX_ROOMS = 16;
    localparam int CFG_W         = 5;
    localparam int TIME_W        = 32;
    localparam int ROOM_W        = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // take the request, latch times, start the scan
        logic scan;     // scan of the room entries in progress
        logic resolve;  // pick the room at the end of the scan
        logic update;   // write back the room and load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;      // entry under evaluation is free at the requested start
        logic last;     // entry under evaluation is the last room in use
        logic out_free; // result register can take a new result
    } status_t;

endpackage

[sv/room_allocation_scheduler.sv]
// ----------------------------------------------------------------------------
// room_allocation_scheduler
// assigns each meeting request to a room and tracks the most-booked room
// ----------------------------------------------------------------------------
// Each request is placed in the lowest-numbered room (of the first room_count
// rooms) that is free at its start; if none is free it goes to the room that
// frees earliest and is pushed back, keeping its duration. One request is
// handled at a time: the scan reads one room entry per cycle from the
// free-time and count memories, up to and including the first free one (at
// most the rooms in use), and the room is then written back. The sequencer
// takes the next request only after it has returned to idle from write-back.
// The result sits in an output register, so the next request is accepted
// while it waits; that request stalls in write-back until the waiting result
// has been taken.
// No clearing pass is needed after reset or new_set: per-room valid bits
// make untouched rooms read as free at time zero with no bookings.
// ----------------------------------------------------------------------------
module room_allocation_scheduler #(
    parameter int MAX_ROOMS = ras_pkg::DEF_MAX_ROOMS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // room count register
    input  logic                         cfg_wr_en,
    input  logic [ras_pkg::CFG_W-1:0]    cfg_wr_data,
    // meeting requests
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_new_set,
    input  logic [ras_pkg::TIME_W-1:0]   s_meeting_start,
    input  logic [ras_pkg::TIME_W-1:0]   s_meeting_end,
    // allocation results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ras_pkg::ROOM_W-1:0]   m_assigned_room,
    output logic [ras_pkg::TIME_W-1:0]   m_actual_start,
    output logic [ras_pkg::TIME_W-1:0]   m_actual_end,
    output logic                         m_was_delayed,
    output logic                         m_time_overflow,
    output logic [ras_pkg::ROOM_W-1:0]   m_most_booked_room,
    output logic [ras_pkg::TIME_W-1:0]   m_most_booked_count
);
    import ras_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: idle, scan of room entries, write-back
    ras_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // room memories, scan evaluation, saturating end and count, result register
    ras_datapath #(
        .MAX_ROOMS (MAX_ROOMS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_new_set           (s_new_set),
        .s_meeting_start     (s_meeting_start),
        .s_meeting_end       (s_meeting_end),
        .cmd                 (cmd),
        .status              (status),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_assigned_room     (m_assigned_room),
        .m_actual_start      (m_actual_start),
        .m_actual_end        (m_actual_end),
        .m_was_delayed       (m_was_delayed),
        .m_time_overflow     (m_time_overflow),
        .m_most_booked_room  (m_most_booked_room),
        .m_most_booked_count (m_most_booked_count)
    );

endmodule

[sv/ras_ram.sv]
// ----------------------------------------------------------------------------
// ras_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ras_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/ras_ctrl.sv]
// ----------------------------------------------------------------------------
// ras_ctrl
// sequencer: accept, scan of the room entries, write-back
// ----------------------------------------------------------------------------
module ras_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ras_pkg::status_t  status,
    output ras_pkg::cmd_t     cmd
);
    import ras_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.hit || status.last) begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold until the previous result has been taken
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/ras_datapath.sv]
// ----------------------------------------------------------------------------
// ras_datapath
// room stores, scan evaluation, booking update and result register
// ----------------------------------------------------------------------------
module ras_datapath #(
    parameter int MAX_ROOMS = ras_pkg::DEF_MAX_ROOMS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ras_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         s_new_set,
    input  logic [ras_pkg::TIME_W-1:0]   s_meeting_start,
    input  logic [ras_pkg::TIME_W-1:0]   s_meeting_end,
    input  ras_pkg::cmd_t                cmd,
    output ras_pkg::status_t             status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ras_pkg::ROOM_W-1:0]   m_assigned_room,
    output logic [ras_pkg::TIME_W-1:0]   m_actual_start,
    output logic [ras_pkg::TIME_W-1:0]   m_actual_end,
    output logic                         m_was_delayed,
    output logic                         m_time_overflow,
    output logic [ras_pkg::ROOM_W-1:0]   m_most_booked_room,
    output logic [ras_pkg::TIME_W-1:0]   m_most_booked_count
);
    import ras_pkg::*;

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int N_W   = $clog2(MAX_ROOMS + 1);
    localparam int RC_W  = (N_W > CFG_W) ? N_W : CFG_W;

    // configuration
    logic [RC_W-1:0]   room_count_reg;

    // request
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [IDX_W-1:0]  last_idx_reg;
    logic [IDX_W-1:0]  last_idx_next;

    // read issue and evaluation pipeline
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              issuing_reg;
    logic              rd_en;
    logic              ev_vld_reg;
    logic [IDX_W-1:0]  ev_idx_reg;
    logic              ev_vbit_reg;
    logic [MAX_ROOMS-1:0] valid_reg;

    logic [TIME_W-1:0] free_rdata;
    logic [TIME_W-1:0] cnt_rdata;
    logic [TIME_W-1:0] eff_free;
    logic [TIME_W-1:0] eff_cnt;
    logic              hit;
    logic              take_cur;

    // earliest-freeing room seen so far
    logic [TIME_W-1:0] min_free_reg;
    logic [TIME_W-1:0] min_cnt_reg;
    logic [IDX_W-1:0]  min_idx_reg;

    // chosen room
    logic [IDX_W-1:0]  room_reg;
    logic [TIME_W-1:0] act_start_reg;
    logic [TIME_W-1:0] cnt_reg;
    logic              delayed_reg;

    // write-back
    logic [TIME_W:0]   end_sum;
    logic              ovf;
    logic [TIME_W-1:0] act_end;
    logic [TIME_W-1:0] new_cnt;
    logic              better;

    // most-booked record
    logic [IDX_W-1:0]  best_room_reg;
    logic [TIME_W-1:0] best_count_reg;

    // result register
    logic              m_valid_reg;
    logic [ROOM_W-1:0] out_room_reg;
    logic [TIME_W-1:0] out_start_reg;
    logic [TIME_W-1:0] out_end_reg;
    logic              out_delayed_reg;
    logic              out_ovf_reg;
    logic [ROOM_W-1:0] out_best_room_reg;
    logic [TIME_W-1:0] out_best_count_reg;

    // rooms in use minus one, out-of-range counts clamped
    always_comb begin
        if (room_count_reg == '0) begin
            last_idx_next = '0;
        end else if (int'(room_count_reg) > MAX_ROOMS) begin
            last_idx_next = IDX_W'(MAX_ROOMS - 1);
        end else begin
            last_idx_next = IDX_W'(room_count_reg - RC_W'(1));
        end
    end

    assign rd_en = cmd.scan && issuing_reg;

    ras_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_ROOMS)
    ) u_free_ram (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (room_reg),
        .wdata (act_end),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (free_rdata)
    );

    ras_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_ROOMS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (room_reg),
        .wdata (new_cnt),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (cnt_rdata)
    );

    // entries never written since the last clear read as zero
    assign eff_free = ev_vbit_reg ? free_rdata : '0;
    assign eff_cnt  = ev_vbit_reg ? cnt_rdata  : '0;
    assign hit      = ev_vld_reg && (eff_free <= start_reg);
    assign take_cur = (ev_idx_reg == '0) || (eff_free < min_free_reg);

    assign status.hit      = hit;
    assign status.last     = ev_vld_reg && (ev_idx_reg == last_idx_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    assign end_sum = {1'b0, act_start_reg} + {1'b0, dur_reg};
    assign ovf     = end_sum[TIME_W];
    assign act_end = ovf ? TIME_MAX : end_sum[TIME_W-1:0];
    assign new_cnt = (cnt_reg == TIME_MAX) ? cnt_reg : cnt_reg + TIME_W'(1);
    assign better  = (new_cnt > best_count_reg) ||
                     ((new_cnt == best_count_reg) && (room_reg < best_room_reg));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_count_reg <= RC_W'(MAX_ROOMS);
            issuing_reg    <= 1'b0;
            ev_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            best_room_reg  <= '0;
            best_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                room_count_reg <= RC_W'(cfg_wr_data);
            end
            if (cmd.accept) begin
                issuing_reg <= 1'b1;
                if (s_new_set) begin
                    valid_reg      <= '0;
                    best_room_reg  <= '0;
                    best_count_reg <= '0;
                end
            end else if (rd_en && (rd_idx_reg == last_idx_reg)) begin
                issuing_reg <= 1'b0;
            end else if (cmd.resolve) begin
                issuing_reg <= 1'b0;
            end
            ev_vld_reg <= rd_en && !cmd.resolve;
            if (cmd.update) begin
                valid_reg[room_reg] <= 1'b1;
                if (better) begin
                    best_room_reg  <= room_reg;
                    best_count_reg <= new_cnt;
                end
            end
            if (cmd.update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            start_reg    <= s_meeting_start;
            dur_reg      <= (s_meeting_end > s_meeting_start) ?
                            s_meeting_end - s_meeting_start : '0;
            last_idx_reg <= last_idx_next;
            rd_idx_reg   <= '0;
        end else if (rd_en) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
        if (rd_en) begin
            ev_idx_reg  <= rd_idx_reg;
            ev_vbit_reg <= valid_reg[rd_idx_reg];
        end
        if (cmd.scan && ev_vld_reg && take_cur) begin
            min_free_reg <= eff_free;
            min_cnt_reg  <= eff_cnt;
            min_idx_reg  <= ev_idx_reg;
        end
        if (cmd.resolve) begin
            if (hit) begin
                room_reg      <= ev_idx_reg;
                act_start_reg <= start_reg;
                cnt_reg       <= eff_cnt;
                delayed_reg   <= 1'b0;
            end else if (take_cur) begin
                room_reg      <= ev_idx_reg;
                act_start_reg <= eff_free;
                cnt_reg       <= eff_cnt;
                delayed_reg   <= 1'b1;
            end else begin
                room_reg      <= min_idx_reg;
                act_start_reg <= min_free_reg;
                cnt_reg       <= min_cnt_reg;
                delayed_reg   <= 1'b1;
            end
        end
        if (cmd.update) begin
            out_room_reg    <= ROOM_W'(room_reg);
            out_start_reg   <= act_start_reg;
            out_end_reg     <= act_end;
            out_delayed_reg <= delayed_reg;
            out_ovf_reg     <= ovf;
            if (better) begin
                out_best_room_reg  <= ROOM_W'(room_reg);
                out_best_count_reg <= new_cnt;
            end else begin
                out_best_room_reg  <= ROOM_W'(best_room_reg);
                out_best_count_reg <= best_count_reg;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_assigned_room     = out_room_reg;
    assign m_actual_start      = out_start_reg;
    assign m_actual_end        = out_end_reg;
    assign m_was_delayed       = out_delayed_reg;
    assign m_time_overflow     = out_ovf_reg;
    assign m_most_booked_room  = out_best_room_reg;
    assign m_most_booked_count = out_best_count_reg;

endmodule

[test/room_allocation_scheduler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_allocation_scheduler_test
// self-checking bench for the meeting room allocator
// ----------------------------------------------------------------------------
// Meeting requests are offered on the s_ channel and allocation results are
// taken from the m_ channel, with random gaps and stalls on both sides. A
// behavioural allocator in the bench tracks room free times, booking counts
// and the most-booked record, and queues the expected result for every
// accepted request. Every result is checked field by field against the
// oldest queued entry. Directed cases cover the field extremes, the room
// count limits, delays, saturated end times and a room count change within a
// set. A back-pressure case and about a thousand random requests, grouped in
// mostly well-formed sets, follow.
// ----------------------------------------------------------------------------
module room_allocation_scheduler_test;
    import ras_pkg::*;

    localparam int MAX_ROOMS = DEF_MAX_ROOMS;

    // expected allocation for one request
    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              delayed;
        logic              saturated;
        logic [ROOM_W-1:0] top_room;
        logic [TIME_W-1:0] top_count;
    } allocation_t;

    // clock and synchronous active-low reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #4 aclk = ~aclk;

    // block inputs, all known from time zero
    logic              cfg_wr_en       = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data     = '0;
    logic              s_valid         = 1'b0;
    logic              s_new_set       = 1'b0;
    logic [TIME_W-1:0] s_meeting_start = '0;
    logic [TIME_W-1:0] s_meeting_end   = '0;
    logic              m_ready         = 1'b0;

    // block outputs
    logic              s_ready;
    logic              m_valid;
    logic [ROOM_W-1:0] m_assigned_room;
    logic [TIME_W-1:0] m_actual_start;
    logic [TIME_W-1:0] m_actual_end;
    logic              m_was_delayed;
    logic              m_time_overflow;
    logic [ROOM_W-1:0] m_most_booked_room;
    logic [TIME_W-1:0] m_most_booked_count;

    // allocator state mirrored in the bench
    logic [TIME_W-1:0] free_at  [MAX_ROOMS];
    logic [TIME_W-1:0] bookings [MAX_ROOMS];
    logic [ROOM_W-1:0] top_room;
    logic [TIME_W-1:0] top_count;
    logic [CFG_W-1:0]  room_limit;

    // allocations still owed by the block, oldest first
    allocation_t pending_allocations[$];
    allocation_t oldest;

    int unsigned mismatches      = 0;
    int unsigned ready_hold      = 0;
    int unsigned result_hold_off = 0;  // long receiver hold-off, set by a test
    bit          steady          = 1'b0;  // no gaps and no stalls while set

    room_allocation_scheduler #(
        .MAX_ROOMS(MAX_ROOMS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_new_set          (s_new_set),
        .s_meeting_start    (s_meeting_start),
        .s_meeting_end      (s_meeting_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_assigned_room    (m_assigned_room),
        .m_actual_start     (m_actual_start),
        .m_actual_end       (m_actual_end),
        .m_was_delayed      (m_was_delayed),
        .m_time_overflow    (m_time_overflow),
        .m_most_booked_room (m_most_booked_room),
        .m_most_booked_count(m_most_booked_count)
    );

    // ------------------------------------------------------------------------
    // behavioural allocator
    // ------------------------------------------------------------------------

    // empty every room and forget the most-booked record
    function automatic void clear_rooms();
        for (int k = 0; k < MAX_ROOMS; k++) begin
            free_at[k]  = '0;
            bookings[k] = '0;
        end
        top_room  = '0;
        top_count = '0;
    endfunction

    // place one request and return what the block should report for it
    function automatic allocation_t allocate_meeting(input logic new_set,
                                                     input logic [TIME_W-1:0] req_start,
                                                     input logic [TIME_W-1:0] req_end);
        allocation_t       a;
        int                rooms;
        int                pick;
        bit                found;
        logic [TIME_W-1:0] duration;

        if (new_set)
            clear_rooms();

        // a count of zero behaves as one room, anything above the maximum as the maximum
        if (room_limit == 0)
            rooms = 1;
        else if (room_limit > MAX_ROOMS)
            rooms = MAX_ROOMS;
        else
            rooms = int'(room_limit);

        // an end at or before the start gives a zero-length meeting
        duration = (req_end > req_start) ? req_end - req_start : '0;

        // lowest-numbered room already free at the requested start
        found = 1'b0;
        pick  = 0;
        for (int k = 0; k < rooms; k++) begin
            if (!found && free_at[k] <= req_start) begin
                pick  = k;
                found = 1'b1;
            end
        end

        // otherwise the room that frees earliest, lowest number on a tie
        if (!found) begin
            for (int k = 1; k < rooms; k++) begin
                if (free_at[k] < free_at[pick])
                    pick = k;
            end
        end

        a.room       = ROOM_W'(pick);
        a.delayed    = !found;
        a.start_time = found ? req_start : free_at[pick];

        // end time clips at the top of the time range
        if (duration > TIME_MAX - a.start_time) begin
            a.end_time  = TIME_MAX;
            a.saturated = 1'b1;
        end else begin
            a.end_time  = a.start_time + duration;
            a.saturated = 1'b0;
        end

        free_at[pick] = a.end_time;
        if (bookings[pick] != TIME_MAX)
            bookings[pick] = bookings[pick] + TIME_W'(1);

        // rooms outside the current count keep their bookings in the record
        if (bookings[pick] > top_count || (bookings[pick] == top_count && pick < top_room)) begin
            top_count = bookings[pick];
            top_room  = ROOM_W'(pick);
        end

        a.top_room  = top_room;
        a.top_count = top_count;
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one request after a random gap and queue its expected allocation
    // on acceptance; valid is left high so a back-to-back request can follow
    task automatic send_meeting(input logic new_set,
                                input logic [TIME_W-1:0] req_start,
                                input logic [TIME_W-1:0] req_end);
        int gap;

        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_new_set       <= new_set;
        s_meeting_start <= req_start;
        s_meeting_end   <= req_end;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        pending_allocations.insert(pending_allocations.size(),
                                   allocate_meeting(new_set, req_start, req_end));
    endtask

    // stop offering and wait for every owed allocation to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_allocations.size() != 0)
            @(posedge aclk);
    endtask

    // room count writes happen only with the block idle
    task automatic set_room_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        room_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, optional long hold-off, checking
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
        mismatches++;
        $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_allocations.size() == 0) begin
                    note_mismatch("result with no request owed",
                                  TIME_W'(m_assigned_room), '0);
                end else begin
                    oldest = pending_allocations.pop_front();
                    if (m_assigned_room !== oldest.room)
                        note_mismatch("assigned_room", TIME_W'(m_assigned_room),
                                      TIME_W'(oldest.room));
                    if (m_actual_start !== oldest.start_time)
                        note_mismatch("actual_start", m_actual_start, oldest.start_time);
                    if (m_actual_end !== oldest.end_time)
                        note_mismatch("actual_end", m_actual_end, oldest.end_time);
                    if (m_was_delayed !== oldest.delayed)
                        note_mismatch("was_delayed", TIME_W'(m_was_delayed),
                                      TIME_W'(oldest.delayed));
                    if (m_time_overflow !== oldest.saturated)
                        note_mismatch("time_overflow", TIME_W'(m_time_overflow),
                                      TIME_W'(oldest.saturated));
                    if (m_most_booked_room !== oldest.top_room)
                        note_mismatch("most_booked_room", TIME_W'(m_most_booked_room),
                                      TIME_W'(oldest.top_room));
                    if (m_most_booked_count !== oldest.top_count)
                        note_mismatch("most_booked_count", m_most_booked_count,
                                      oldest.top_count);
                end
                ready_hold = steady ? 0 : $urandom_range(0, 6);
            end
            // a requested hold-off replaces the normal stall
            if (result_hold_off != 0) begin
                ready_hold      = result_hold_off;
                result_hold_off = 0;
            end
            if (ready_hold != 0) begin
                m_ready <= 1'b0;
                ready_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // all sixteen rooms: zero-length meetings, end before start, full range
    task automatic test_directed_basics();
        send_meeting(1'b1, 32'd0, 32'd0);
        send_meeting(1'b0, 32'd5, 32'd3);
        send_meeting(1'b0, 32'd10, 32'd20);
        send_meeting(1'b0, 32'd15, 32'd40);
        send_meeting(1'b0, TIME_MAX - 1, TIME_MAX);
        send_meeting(1'b1, 32'd0, TIME_MAX);
    endtask

    // one room, zero rooms, and counts above the maximum
    task automatic test_room_count_limits();
        set_room_count(5'd1);
        send_meeting(1'b1, 32'd100, 32'd200);
        send_meeting(1'b0, 32'd150, 32'd300);
        send_meeting(1'b0, 32'd160, 32'd170);
        set_room_count(5'd0);
        send_meeting(1'b0, 32'd400, 32'd410);
        set_room_count(5'd31);
        send_meeting(1'b0, 32'd405, 32'd500);
        set_room_count(5'd17);
        send_meeting(1'b0, 32'd406, 32'd0);
    endtask

    // two rooms near the top of the time range: ties, delays, saturation
    task automatic test_delay_and_saturation();
        set_room_count(5'd2);
        send_meeting(1'b1, 32'd0, TIME_MAX - 15);
        send_meeting(1'b0, 32'd1, TIME_MAX - 15);
        send_meeting(1'b0, 32'd2, 32'h0000_0102);
        send_meeting(1'b0, 32'd3, 32'd4);
        send_meeting(1'b0, 32'd5, 32'h0000_0010);
        // start at the very top of the time range
        send_meeting(1'b0, TIME_MAX, TIME_MAX);
    endtask

    // most-booked room left outside the scan after the count shrinks
    task automatic test_count_change_within_set();
        set_room_count(5'd16);
        send_meeting(1'b1, 32'd0, 32'd100);
        send_meeting(1'b0, 32'd1, 32'd100);
        send_meeting(1'b0, 32'd2, 32'd100);
        send_meeting(1'b0, 32'd3, 32'd10);
        send_meeting(1'b0, 32'd20, 32'd30);
        set_room_count(5'd2);
        send_meeting(1'b0, 32'd40, 32'd50);
    endtask

    // results held off for a long stretch so the block stalls its input
    task automatic test_input_backpressure();
        logic [TIME_W-1:0] t;

        set_room_count(5'd4);
        steady          = 1'b1;
        result_hold_off = 150;
        t = $urandom_range(0, 1000);
        for (int k = 0; k < 24; k++) begin
            t = t + $urandom_range(1, 30);
            send_meeting(k == 0, t, t + $urandom_range(1, 200));
        end
        drain_results();
        steady = 1'b0;
    endtask

    // random sets: mostly increasing starts with random lengths, some noise
    task automatic test_random_sets(input int unsigned total);
        int unsigned       sent;
        int unsigned       len;
        int unsigned       kind;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] req_start;
        logic [TIME_W-1:0] req_end;
        logic              new_set;

        sent = 0;
        while (sent < total) begin
            // new room count between sets now and then, extremes included
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0: set_room_count(5'd0);
                    1: set_room_count(5'd1);
                    2: set_room_count(5'd16);
                    3: set_room_count(5'd31);
                    4: set_room_count(CFG_W'($urandom_range(2, 15)));
                    5: set_room_count(CFG_W'($urandom_range(17, 30)));
                    default: set_room_count(CFG_W'($urandom_range(1, 16)));
                endcase
            end
            steady = ($urandom_range(0, 4) == 0);
            len    = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
                0: t = $urandom();
                1: t = TIME_MAX - $urandom_range(0, 4000);
                default: t = $urandom_range(0, 1000);
            endcase
            for (int unsigned k = 0; k < len && sent < total; k++) begin
                kind = $urandom_range(0, 19);
                // a wrap near the top simply gives an out-of-order start
                t         = t + $urandom_range(1, 40);
                req_start = t;
                req_end   = req_start + $urandom_range(1, 300);
                // most sets open with a clear, some carry on from the last one
                new_set   = (k == 0) && ($urandom_range(0, 7) != 0);
                case (kind)
                    0: req_end   = req_start - $urandom_range(0, 3);
                    1: req_end   = $urandom();
                    2: req_start = $urandom();
                    3: req_end   = req_start + $urandom();
                    4: new_set   = 1'($urandom_range(0, 1));
                    default: ;
                endcase
                send_meeting(new_set, req_start, req_end);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        clear_rooms();
        room_limit = MAX_ROOMS;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_basics();
        test_room_count_limits();
        test_delay_and_saturation();
        test_count_change_within_set();
        test_input_backpressure();
        test_random_sets(1000);

        // every request answered, then a little longer than one full scan
        drain_results();
        repeat (25) @(posedge aclk);
        if (mismatches == 0 && pending_allocations.size() == 0)
            $display("[room_allocation_scheduler] OK");
        else
            $display("[room_allocation_scheduler] ERROR");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("[room_allocation_scheduler] ERROR");
        $finish;
    end

endmodule
